>>> rtl/fuzzy_match_scorer_macros.svh
// assertion macros for the fuzzy match scorer
// expects clk and rst_n in the scope of every use
`ifndef FUZZY_MATCH_SCORER_MACROS_SVH
`define FUZZY_MATCH_SCORER_MACROS_SVH

// consequent in the cycle after the antecedent
`define FMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the same cycle as the antecedent
`define FMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/fms_pkg.sv
// shared types, constants and a function of the fuzzy match scorer
// no dependencies
package fms_pkg;

  localparam int CHAR_W   = 8;
  localparam int QCHARS   = 16;
  localparam int QLEN_W   = 5;
  localparam int SCORE_W  = 17;
  localparam int KIND_W   = 3;
  localparam int CFG_W    = 64;
  localparam int ADDR_W   = 5;

  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    REG_QLEN   = 2'd0,
    REG_QLOW   = 2'd1,
    REG_QHIGH  = 2'd2
  } fms_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_EXACT  = 3'd2,
    KIND_PREFIX = 3'd3,
    KIND_SUBSTR = 3'd4,
    KIND_SUBSEQ = 3'd5
  } fms_kind_t;

  typedef logic [QCHARS-1:0][CHAR_W-1:0] fms_query_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              last_char;
  } fms_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]         match_kind;
    logic                      keep;
  } fms_out_t;

  typedef struct packed {
    logic              prefix_eq;
    logic              found;
    logic [QLEN_W-1:0] qlen;
    logic [QLEN_W-1:0] progress;
  } fms_flags_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] r;
    r = b;
    if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

>>> rtl/fms_cell.sv
// one window cell: holds one candidate character and checks its input character against
// the query character aligned to its place; uses fms_pkg
module fms_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift,
  input  logic                       clear,
  input  logic [fms_pkg::CHAR_W-1:0] char_in,
  output logic [fms_pkg::CHAR_W-1:0] char_out,
  input  fms_pkg::fms_query_t        query,
  input  logic [fms_pkg::QLEN_W-1:0] qlen,
  output logic                       hit
);

  logic [fms_pkg::CHAR_W-1:0] char_r;
  logic [fms_pkg::CHAR_W-1:0] char_nxt;
  logic [fms_pkg::QLEN_W-1:0] sel_full;
  logic                       active;

  always_comb begin
    char_nxt = char_r;
    if (clear) begin
      char_nxt = '0;
    end else if (shift) begin
      char_nxt = char_in;
    end
  end

  // occurrence ending at the newest character: cell i meets query char qlen-1-i
  assign active   = fms_pkg::QLEN_W'(IDX) < qlen;
  assign sel_full = qlen - fms_pkg::QLEN_W'(IDX) - fms_pkg::QLEN_W'(1);
  assign hit      = !active || (char_in == query[sel_full[3:0]]);
  assign char_out = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_r <= '0;
    end else begin
      char_r <= char_nxt;
    end
  end

endmodule

>>> rtl/fms_score.sv
// score selection for one finished candidate
// uses fms_pkg
module fms_score #(
  parameter int POSITION_WIDTH = 16
) (
  input  fms_pkg::fms_flags_t       flags,
  input  logic [POSITION_WIDTH-1:0] pos,
  input  logic [POSITION_WIDTH-1:0] fmp,
  output fms_pkg::fms_out_t         result
);

  localparam int SW = ((POSITION_WIDTH > fms_pkg::SCORE_W) ?
                       POSITION_WIDTH : fms_pkg::SCORE_W) + 2;

  localparam logic signed [SW-1:0] S_EMPTY  = 1;
  localparam logic signed [SW-1:0] S_EXACT  = 1000;
  localparam logic signed [SW-1:0] S_PREFIX = 500;
  localparam logic signed [SW-1:0] S_SUBSTR = 300;
  localparam logic signed [SW-1:0] S_SUBSEQ = 100;

  logic signed [SW-1:0]      pos_x;
  logic signed [SW-1:0]      fmp_x;
  logic signed [SW-1:0]      qlen_x;
  logic signed [SW-1:0]      exact;
  logic [POSITION_WIDTH-1:0] qlen_p;
  fms_pkg::fms_kind_t        kind;

  assign pos_x  = signed'(SW'(pos));
  assign fmp_x  = signed'(SW'(fmp));
  assign qlen_x = signed'(SW'(flags.qlen));
  assign qlen_p = POSITION_WIDTH'(flags.qlen);

  always_comb begin
    priority if (flags.qlen == '0) begin
      kind  = fms_pkg::KIND_EMPTY;
      exact = S_EMPTY;
    end else if (flags.prefix_eq && pos == qlen_p) begin
      kind  = fms_pkg::KIND_EXACT;
      exact = S_EXACT;
    end else if (flags.prefix_eq && pos > qlen_p) begin
      kind  = fms_pkg::KIND_PREFIX;
      exact = S_PREFIX;
    end else if (flags.found) begin
      kind  = fms_pkg::KIND_SUBSTR;
      exact = S_SUBSTR - fmp_x;
    end else if (flags.progress == flags.qlen) begin
      kind  = fms_pkg::KIND_SUBSEQ;
      exact = S_SUBSEQ - pos_x + qlen_x;
    end else begin
      kind  = fms_pkg::KIND_NONE;
      exact = '0;
    end
  end

  assign result.score      = exact[fms_pkg::SCORE_W-1:0];
  assign result.match_kind = kind;
  assign result.keep       = exact > 0;

endmodule

>>> rtl/fuzzy_match_scorer.sv
// fuzzy match scorer top level: config registers, cell row, result pipeline
// result path: the transaction marked last_char loads the score stage register, then the output register
// throughput: one character transaction per cycle while in_ready is high, set by the cell row compare
// and position/flag update that finish in the same cycle as the character
// reset clears query registers, candidate state and both pipeline valid flags
`include "fuzzy_match_scorer_macros.svh"
module fuzzy_match_scorer #(
  parameter int MAX_QUERY_LENGTH = 16,
  parameter int POSITION_WIDTH   = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fms_pkg::fms_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fms_pkg::fms_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fms_pkg::ADDR_W-1:0] paddr,
  input  logic [fms_pkg::CFG_W-1:0]  pwdata,
  output logic [fms_pkg::CFG_W-1:0]  prdata,
  output logic                       pready
);

  localparam int PW = POSITION_WIDTH;

  // config registers
  logic [fms_pkg::QLEN_W-1:0] qlen_reg_r;
  logic [fms_pkg::CFG_W-1:0]  qlow_r;
  logic [fms_pkg::CFG_W-1:0]  qhigh_r;
  logic                       cfg_wr;
  fms_pkg::fms_reg_t          cfg_sel;

  // candidate state
  logic [PW-1:0]              pos_r, pos_nxt, pos_upd, pos_cand;
  logic                       prefix_r, prefix_nxt, prefix_upd, prefix_cand;
  logic                       found_r, found_nxt, found_upd, found_cand;
  logic [PW-1:0]              fmp_r, fmp_nxt, fmp_upd, fmp_cand;
  logic [fms_pkg::QLEN_W-1:0] prog_r, prog_nxt, prog_upd, prog_cand;

  // result pipeline
  logic                       s2_valid_r;
  fms_pkg::fms_flags_t        s2_flags_r;
  logic [PW-1:0]              s2_pos_r;
  logic [PW-1:0]              s2_fmp_r;
  logic                       out_valid_r;
  fms_pkg::fms_out_t          out_data_r;
  fms_pkg::fms_out_t          score_res;
  logic                       out_adv;
  logic                       s2_ready;

  logic                       accept;
  logic                       present;
  logic                       fin;
  logic [fms_pkg::CHAR_W-1:0] c;
  logic [fms_pkg::QLEN_W-1:0] qlen;
  fms_pkg::fms_query_t        query;
  logic [2*fms_pkg::CFG_W-1:0] qraw;
  logic [fms_pkg::CHAR_W-1:0] chain [MAX_QUERY_LENGTH+1];
  logic [MAX_QUERY_LENGTH-1:0] hits;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = fms_pkg::fms_reg_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_sel)
      fms_pkg::REG_QLEN:  prdata = fms_pkg::CFG_W'(qlen_reg_r);
      fms_pkg::REG_QLOW:  prdata = qlow_r;
      fms_pkg::REG_QHIGH: prdata = qhigh_r;
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_reg_r <= '0;
      qlow_r     <= '0;
      qhigh_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        fms_pkg::REG_QLEN:  qlen_reg_r <= pwdata[fms_pkg::QLEN_W-1:0];
        fms_pkg::REG_QLOW:  qlow_r     <= pwdata;
        fms_pkg::REG_QHIGH: qhigh_r    <= pwdata;
        default: ;
      endcase
    end
  end

  assign qlen = (qlen_reg_r > fms_pkg::QLEN_W'(MAX_QUERY_LENGTH)) ?
                fms_pkg::QLEN_W'(MAX_QUERY_LENGTH) : qlen_reg_r;
  assign qraw = {qhigh_r, qlow_r};

  always_comb begin
    for (int j = 0; j < fms_pkg::QCHARS; j++) begin
      query[j] = fms_pkg::fold(qraw[fms_pkg::CHAR_W*j +: fms_pkg::CHAR_W]);
    end
  end

  // handshake
  assign out_adv  = !out_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || out_adv;
  assign in_ready = s2_ready;
  assign accept   = in_valid && in_ready;
  assign present  = accept && in_data.char_present;
  assign fin      = accept && in_data.last_char;
  assign c        = fms_pkg::fold(in_data.char_code);

  // window cell row
  assign chain[0] = c;

  for (genvar i = 0; i < MAX_QUERY_LENGTH; i++) begin : g_cell
    fms_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (present),
      .clear    (fin),
      .char_in  (chain[i]),
      .char_out (chain[i+1]),
      .query    (query),
      .qlen     (qlen),
      .hit      (hits[i])
    );
  end

  always_comb begin
    prefix_upd = prefix_r;
    if (pos_r < PW'(qlen) && c != query[pos_r[3:0]]) begin
      prefix_upd = 1'b0;
    end
    prog_upd = prog_r;
    if (prog_r < qlen && c == query[prog_r[3:0]]) begin
      prog_upd = prog_r + fms_pkg::QLEN_W'(1);
    end
    pos_upd = (pos_r != '1) ? pos_r + PW'(1) : pos_r;
    found_upd = found_r;
    fmp_upd   = fmp_r;
    if (!found_r && qlen != '0 && pos_upd >= PW'(qlen) && (&hits)) begin
      found_upd = 1'b1;
      fmp_upd   = pos_upd - PW'(qlen);
    end

    pos_cand    = present ? pos_upd    : pos_r;
    prefix_cand = present ? prefix_upd : prefix_r;
    found_cand  = present ? found_upd  : found_r;
    fmp_cand    = present ? fmp_upd    : fmp_r;
    prog_cand   = present ? prog_upd   : prog_r;

    if (fin) begin
      pos_nxt    = '0;
      prefix_nxt = 1'b1;
      found_nxt  = 1'b0;
      fmp_nxt    = '0;
      prog_nxt   = '0;
    end else begin
      pos_nxt    = pos_cand;
      prefix_nxt = prefix_cand;
      found_nxt  = found_cand;
      fmp_nxt    = fmp_cand;
      prog_nxt   = prog_cand;
    end
  end

  fms_score #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_score (
    .flags  (s2_flags_r),
    .pos    (s2_pos_r),
    .fmp    (s2_fmp_r),
    .result (score_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      prefix_r    <= 1'b1;
      found_r     <= 1'b0;
      fmp_r       <= '0;
      prog_r      <= '0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      prefix_r <= prefix_nxt;
      found_r  <= found_nxt;
      fmp_r    <= fmp_nxt;
      prog_r   <= prog_nxt;
      if (s2_ready) begin
        s2_valid_r <= fin;
      end
      if (out_adv) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      s2_flags_r.prefix_eq <= prefix_cand;
      s2_flags_r.found     <= found_cand;
      s2_flags_r.qlen      <= qlen;
      s2_flags_r.progress  <= prog_cand;
      s2_pos_r             <= pos_cand;
      s2_fmp_r             <= fmp_cand;
    end
    if (out_adv) begin
      out_data_r <= score_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FMS_ASSERT_NEXT(a_last_loads_stage, fin, s2_valid_r, "last transaction did not load the score stage")
  `FMS_ASSERT_NEXT(a_clear_after_last, fin, (pos_r == '0) && (prog_r == '0) && !found_r && prefix_r && (chain[MAX_QUERY_LENGTH] == '0), "candidate state not cleared after last transaction")
  `FMS_ASSERT_NOW(a_prog_bound, 1'b1, prog_r <= fms_pkg::QLEN_W'(MAX_QUERY_LENGTH), "subsequence progress beyond query size")
  `FMS_ASSERT_NOW(a_fmp_behind_pos, found_r, fmp_r <= pos_r, "occurrence start ahead of position")
  `FMS_ASSERT_NOW(a_empty_scores_one, out_valid_r && (out_data_r.match_kind == fms_pkg::KIND_EMPTY), out_data_r.score == 17'sd1, "empty query result not scored one")

endmodule
